/* design/mmfc_pkg.sv */
// ----------------------------------------------------------------------------
// Frame checksum package
// Mode codes, polynomial constants and the types shared by the checksum core.
// ----------------------------------------------------------------------------
package mmfc_pkg;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_NONE     = 3'd0;
    localparam t_mode MODE_NEG_ADD8 = 3'd1;
    localparam t_mode MODE_ADD8     = 3'd2;
    localparam t_mode MODE_XOR8     = 3'd3;
    localparam t_mode MODE_ADD16    = 3'd4;
    localparam t_mode MODE_MODBUS   = 3'd5;
    localparam t_mode MODE_CCITT    = 3'd6;
    localparam t_mode MODE_CRC32    = 3'd7;

    localparam logic [31:0] CRC32_POLY   = 32'hEDB8_8320;
    localparam logic [15:0] MODBUS_POLY  = 16'hA001;
    localparam logic [15:0] CCITT_POLY   = 16'h1021;
    localparam logic [15:0] CRC16_INIT   = 16'hFFFF;
    localparam logic [31:0] CRC32_INIT   = 32'hFFFF_FFFF;
    localparam logic [15:0] CCITT_MSB    = 16'h8000;

    localparam int unsigned CHECK_W      = 32;
    localparam int unsigned MAX_BYTES    = 4;
    localparam int unsigned CNT_W        = 3;

    // Closing value of a frame handed to the output serializer.
    typedef struct packed {
        logic               load;
        t_mode              mode;
        logic [CHECK_W-1:0] value;
    } t_emit_load;

endpackage

/* design/mmfc_in_if.sv */
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel that carries one frame byte and its end marker.
// ----------------------------------------------------------------------------
interface mmfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

/* design/mmfc_out_if.sv */
// ----------------------------------------------------------------------------
// Check byte channel
// Valid/ready channel that carries one check byte and its last marker.
// ----------------------------------------------------------------------------
interface mmfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] check_byte;
    logic       check_last;

    modport source (output valid, output check_byte, output check_last, input ready);
    modport sink   (input valid, input check_byte, input check_last, output ready);
endinterface

/* design/multi_mode_frame_checksum_core.sv */
// ----------------------------------------------------------------------------
// Multi-mode frame checksum core
// Folds frame bytes into a selectable checksum or CRC and emits the check
// bytes of each frame after its last byte.
//
//   channel  dir  payload                   transfer when
//   i_in     in   data_byte, frame_end      i_in.valid && i_in.ready
//   o_out    out  check_byte, check_last    o_out.valid && o_out.ready
//   cfg      in   i_cfg_wdata (check_mode)  i_cfg_we
//
// One byte is taken per cycle; the CRC bit steps are unrolled in the fold.
// A frame end byte closes the frame and its 1, 2 or 4 check bytes leave the
// serializer register one per ready cycle, starting the cycle after it.
// Bytes inside a frame are never stalled; a frame end byte waits only while
// the previous frame's check bytes, other than the last one leaving, remain.
// Reset is synchronous: the mode returns to none and no frame is open.
// ----------------------------------------------------------------------------
module multi_mode_frame_checksum_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_wdata,
    mmfc_in_if.sink                       i_in,
    mmfc_out_if.source                    o_out
);

    mmfc_pkg::t_mode              r_mode;
    logic [mmfc_pkg::CHECK_W-1:0] folded;
    logic                         can_load;
    logic                         accept;
    mmfc_pkg::t_emit_load         emit_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mmfc_pkg::MODE_NONE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // A frame end in mode none emits nothing and never needs the serializer.
    assign i_in.ready = !i_in.frame_end || can_load || (r_mode == mmfc_pkg::MODE_NONE);
    assign accept     = i_in.valid && i_in.ready;

    mmfc_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_frame_end (i_in.frame_end),
        .o_folded    (folded)
    );

    always_comb begin
        emit_load.load  = accept && i_in.frame_end && (r_mode != mmfc_pkg::MODE_NONE);
        emit_load.mode  = r_mode;
        emit_load.value = folded;
    end

    mmfc_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (emit_load),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

/* design/mmfc_fold.sv */
// ----------------------------------------------------------------------------
// Running check fold
// Holds the running check value and folds one byte per transfer into it.
// ----------------------------------------------------------------------------
module mmfc_fold (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mmfc_pkg::t_mode              i_mode,
    input  logic                         i_accept,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_frame_end,
    output logic [mmfc_pkg::CHECK_W-1:0] o_folded
);

    logic [mmfc_pkg::CHECK_W-1:0] r_check;
    logic [mmfc_pkg::CHECK_W-1:0] n_check;
    logic                         r_open;
    logic [mmfc_pkg::CHECK_W-1:0] start_val;

    function automatic logic [mmfc_pkg::CHECK_W-1:0] init_value(input mmfc_pkg::t_mode mode);
        logic [mmfc_pkg::CHECK_W-1:0] v;
        v = '0;
        if (mode == mmfc_pkg::MODE_MODBUS || mode == mmfc_pkg::MODE_CCITT) begin
            v = {16'h0000, mmfc_pkg::CRC16_INIT};
        end else if (mode == mmfc_pkg::MODE_CRC32) begin
            v = mmfc_pkg::CRC32_INIT;
        end
        return v;
    endfunction

    // Eight bit steps of each CRC are unrolled; each step is a shift and a
    // conditional XOR.
    function automatic logic [mmfc_pkg::CHECK_W-1:0] fold_byte(
        input mmfc_pkg::t_mode              mode,
        input logic [mmfc_pkg::CHECK_W-1:0] acc,
        input logic [7:0]                   b
    );
        logic [mmfc_pkg::CHECK_W-1:0] res;
        logic [15:0]                  a16;
        logic [31:0]                  a32;
        res = acc;
        a16 = '0;
        a32 = '0;
        case (mode)
            mmfc_pkg::MODE_NEG_ADD8,
            mmfc_pkg::MODE_ADD8,
            mmfc_pkg::MODE_ADD16: begin
                res = acc + {24'h000000, b};
            end
            mmfc_pkg::MODE_XOR8: begin
                res = {24'h000000, acc[7:0] ^ b};
            end
            mmfc_pkg::MODE_MODBUS: begin
                a16 = acc[15:0] ^ {8'h00, b};
                for (int i = 0; i < 8; i++) begin
                    a16 = a16[0] ? ((a16 >> 1) ^ mmfc_pkg::MODBUS_POLY) : (a16 >> 1);
                end
                res = {16'h0000, a16};
            end
            mmfc_pkg::MODE_CCITT: begin
                a16 = acc[15:0] ^ {b, 8'h00};
                for (int i = 0; i < 8; i++) begin
                    a16 = ((a16 & mmfc_pkg::CCITT_MSB) != 16'h0000)
                        ? ((a16 << 1) ^ mmfc_pkg::CCITT_POLY) : (a16 << 1);
                end
                res = {16'h0000, a16};
            end
            mmfc_pkg::MODE_CRC32: begin
                a32 = acc ^ {24'h000000, b};
                for (int i = 0; i < 8; i++) begin
                    a32 = a32[0] ? ((a32 >> 1) ^ mmfc_pkg::CRC32_POLY) : (a32 >> 1);
                end
                res = a32;
            end
            default: begin
                res = acc;
            end
        endcase
        return res;
    endfunction

    always_comb begin
        start_val = r_open ? r_check : init_value(i_mode);
        n_check   = fold_byte(i_mode, start_val, i_data_byte);
    end

    assign o_folded = n_check;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_open <= !i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_check <= n_check;
        end
    end

endmodule

/* design/mmfc_emit.sv */
// ----------------------------------------------------------------------------
// Check byte serializer
// Formats the closing check value of a frame and sends it out byte by byte.
// ----------------------------------------------------------------------------
module mmfc_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mmfc_pkg::t_emit_load i_load,
    output logic                 o_can_load,
    mmfc_out_if.source           o_out
);

    logic [mmfc_pkg::CHECK_W-1:0] r_word;
    logic [mmfc_pkg::CHECK_W-1:0] n_word;
    logic [mmfc_pkg::CNT_W-1:0]   r_cnt;
    logic [mmfc_pkg::CNT_W-1:0]   n_cnt;
    logic [mmfc_pkg::CHECK_W-1:0] fmt_word;
    logic [mmfc_pkg::CNT_W-1:0]   fmt_cnt;
    logic [mmfc_pkg::CHECK_W-1:0] v;
    logic                         xfer;

    assign xfer       = o_out.valid && o_out.ready;
    assign o_can_load = (r_cnt == '0) || (r_cnt == mmfc_pkg::CNT_W'(1) && o_out.ready);

    // The first byte to send always sits in the low byte of the word.
    always_comb begin
        v        = i_load.value;
        fmt_word = '0;
        fmt_cnt  = '0;
        case (i_load.mode)
            mmfc_pkg::MODE_NEG_ADD8: begin
                fmt_word = {24'h000000, 8'h00 - v[7:0]};
                fmt_cnt  = mmfc_pkg::CNT_W'(1);
            end
            mmfc_pkg::MODE_ADD8,
            mmfc_pkg::MODE_XOR8: begin
                fmt_word = {24'h000000, v[7:0]};
                fmt_cnt  = mmfc_pkg::CNT_W'(1);
            end
            mmfc_pkg::MODE_ADD16,
            mmfc_pkg::MODE_CCITT: begin
                fmt_word = {16'h0000, v[7:0], v[15:8]};
                fmt_cnt  = mmfc_pkg::CNT_W'(2);
            end
            mmfc_pkg::MODE_MODBUS: begin
                fmt_word = {16'h0000, v[15:0]};
                fmt_cnt  = mmfc_pkg::CNT_W'(2);
            end
            mmfc_pkg::MODE_CRC32: begin
                fmt_word = ~v;
                fmt_cnt  = mmfc_pkg::CNT_W'(mmfc_pkg::MAX_BYTES);
            end
            default: begin
                fmt_word = '0;
                fmt_cnt  = '0;
            end
        endcase
    end

    always_comb begin
        n_word = r_word;
        n_cnt  = r_cnt;
        if (xfer) begin
            n_word = r_word >> 8;
            n_cnt  = r_cnt - mmfc_pkg::CNT_W'(1);
        end
        if (i_load.load) begin
            n_word = fmt_word;
            n_cnt  = fmt_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.check_byte = r_word[7:0];
    assign o_out.check_last = (r_cnt == mmfc_pkg::CNT_W'(1));

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mmfc_pkg::CNT_W'(mmfc_pkg::MAX_BYTES))
        else $error("serializer byte count out of range");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load |-> o_can_load && i_load.mode != mmfc_pkg::MODE_NONE)
        else $error("frame closed while serializer busy or in mode none");

    a_crc32_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load && i_load.mode == mmfc_pkg::MODE_CRC32
        |=> r_cnt == mmfc_pkg::CNT_W'(mmfc_pkg::MAX_BYTES))
        else $error("CRC-32 frame did not queue four check bytes");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && !o_out.ready && !i_load.load |=> r_cnt == $past(r_cnt))
        else $error("pending check bytes changed during a stall");
`endif

endmodule
